/* sv/bwd_pkg.sv */
// Shared types, constants and the disc trigonometry tables for the vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package bwd_pkg;

    localparam int DISC_SEGMENTS = 16;
    localparam int SEG_W = $clog2(DISC_SEGMENTS + 1);
    localparam int OFF_W = 35;
    localparam int DVD_W = 64;
    localparam int DSR_W = 35;
    localparam int LEN_W = 34;
    localparam logic [31:0] PIX_RESET = 32'd65536;
    localparam logic [63:0] BEAM_MIN_SQ = 64'd43;
    localparam logic [31:0] FADE_SPAN_MIN = 32'd66;
    localparam logic [15:0] RIM_FADE = 16'd768;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] QUARTER_PI_Q30 = 64'd843314857;

    localparam logic [2:0] OP_FLOOR_NEAR = 3'd0;
    localparam logic [2:0] OP_FLOOR_FAR = 3'd1;
    localparam logic [2:0] OP_FLOOR_DISC = 3'd2;
    localparam logic [2:0] OP_NEAR_X = 3'd3;
    localparam logic [2:0] OP_NEAR_Y = 3'd4;
    localparam logic [2:0] OP_FAR_X = 3'd5;
    localparam logic [2:0] OP_FAR_Y = 3'd6;
    localparam logic [2:0] OP_FADE = 3'd7;

    localparam logic CMD_BEAM = 1'b0;
    localparam logic CMD_DISC = 1'b1;

    typedef enum logic [3:0] {
        F_IDLE,
        F_SQX,
        F_SQY,
        F_CHK,
        F_ROOT,
        F_MUL,
        F_START,
        F_WAIT,
        F_RND,
        F_PUSH
    } front_state_t;

    typedef struct packed {
        logic              is_disc;
        logic [31:0]       sx;
        logic [31:0]       sy;
        logic [31:0]       ex;
        logic [31:0]       ey;
        logic [OFF_W-1:0]  nox;
        logic [OFF_W-1:0]  noy;
        logic [OFF_W-1:0]  fox;
        logic [OFF_W-1:0]  foy;
        logic [31:0]       radius;
        logic [15:0]       hot;
        logic [15:0]       cold;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } job_t;

    typedef logic [30:0] trig_mag_t [DISC_SEGMENTS+1];
    typedef logic [DISC_SEGMENTS:0] trig_neg_t;

    function automatic logic [63:0] mq30(logic [63:0] a, logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [31:0] trig_f(int k, bit want_sin);
        logic [63:0] ph;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] co;
        logic [63:0] si;
        logic [2:0]  oct;
        ph = (((64'(k)) << 32) + 64'(DISC_SEGMENTS / 2)) / DISC_SEGMENTS;
        ph = ph & 64'hFFFF_FFFF;
        oct = ph[31:29];
        f = ph & ((64'd1 << 29) - 64'd1);
        if (oct[0]) begin
            f = (64'd1 << 29) - f;
        end
        x = (f * QUARTER_PI_Q30) >> 29;
        x2 = mq30(x, x);
        t = Q30_ONE - x2 / 42;
        t = Q30_ONE - mq30(x2, t) / 20;
        t = Q30_ONE - mq30(x2, t) / 6;
        s = mq30(x, t);
        t = Q30_ONE - x2 / 56;
        t = Q30_ONE - mq30(x2, t) / 30;
        t = Q30_ONE - mq30(x2, t) / 12;
        t = Q30_ONE - mq30(x2, t) / 2;
        c = t;
        case (oct)
            3'd0: begin co = c; si = s; end
            3'd1: begin co = s; si = c; end
            3'd2: begin co = -s; si = c; end
            3'd3: begin co = -c; si = s; end
            3'd4: begin co = -c; si = -s; end
            3'd5: begin co = -s; si = -c; end
            3'd6: begin co = s; si = -c; end
            default: begin co = c; si = -s; end
        endcase
        return want_sin ? si[31:0] : co[31:0];
    endfunction

    function automatic trig_mag_t build_mag(bit want_sin);
        trig_mag_t   tab;
        logic [31:0] v;
        for (int k = 0; k <= DISC_SEGMENTS; k++) begin
            v = trig_f(k, want_sin);
            v = v[31] ? -v : v;
            tab[k] = v[30:0];
        end
        return tab;
    endfunction

    function automatic trig_neg_t build_neg(bit want_sin);
        trig_neg_t   tab;
        logic [31:0] v;
        for (int k = 0; k <= DISC_SEGMENTS; k++) begin
            v = trig_f(k, want_sin);
            tab[k] = v[31];
        end
        return tab;
    endfunction

    localparam trig_mag_t COS_MAG = build_mag(1'b0);
    localparam trig_mag_t SIN_MAG = build_mag(1'b1);
    localparam trig_neg_t COS_NEG = build_neg(1'b0);
    localparam trig_neg_t SIN_NEG = build_neg(1'b1);

    function automatic logic [31:0] sat_add(logic [31:0] base, logic [OFF_W-1:0] off);
        logic [35:0] sum;
        sum = {{4{base[31]}}, base} + {off[OFF_W-1], off};
        if (sum[35] && !(&sum[34:31])) begin
            return 32'h8000_0000;
        end else if (!sum[35] && (|sum[34:31])) begin
            return 32'h7FFF_FFFF;
        end
        return sum[31:0];
    endfunction

endpackage
`default_nettype wire

/* sv/bwd_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bwd_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [bwd_pkg::DVD_W-1:0]   dividend,
    input  wire logic [bwd_pkg::DSR_W-1:0]   divisor,
    output logic                             busy,
    output logic [bwd_pkg::DVD_W-1:0]        quotient,
    output logic [bwd_pkg::DSR_W-1:0]        remainder
);
    localparam int CNT_W = $clog2(bwd_pkg::DVD_W + 1);

    logic                        busy_reg, busy_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [bwd_pkg::DVD_W-1:0]   dq_reg, dq_next;
    logic [bwd_pkg::DSR_W-1:0]   rem_reg, rem_next;
    logic [bwd_pkg::DSR_W-1:0]   dsr_reg, dsr_next;
    logic [bwd_pkg::DSR_W:0]     shifted;
    logic                        ge;

    always_comb begin
        shifted = {rem_reg, dq_reg[bwd_pkg::DVD_W-1]};
        ge = shifted >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        dq_next = dq_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(bwd_pkg::DVD_W);
            dq_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? bwd_pkg::DSR_W'(shifted - {1'b0, dsr_reg})
                          : shifted[bwd_pkg::DSR_W-1:0];
            dq_next = {dq_reg[bwd_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign quotient = dq_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

/* sv/bwd_front.sv */
// Front end: accepts items, computes floors, beam length, offsets and fade.
`timescale 1ns / 1ps
`default_nettype none
module bwd_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_command,
    input  wire logic [31:0]         s_start_x,
    input  wire logic [31:0]         s_start_y,
    input  wire logic [31:0]         s_end_x,
    input  wire logic [31:0]         s_end_y,
    input  wire logic [31:0]         s_near_width,
    input  wire logic [31:0]         s_far_width,
    input  wire logic [7:0]          s_red,
    input  wire logic [7:0]          s_green,
    input  wire logic [7:0]          s_blue,
    input  wire logic [15:0]         s_fade_begin,
    input  wire logic [31:0]         s_fade_span,
    output logic                     job_valid,
    input  wire logic                job_ready,
    output bwd_pkg::job_t            job
);
    bwd_pkg::front_state_t state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [31:0] pix_reg, pix_next;
    logic [31:0] fl_near_reg, fl_near_next;
    logic [31:0] fl_far_reg, fl_far_next;
    logic [31:0] fl_disc_reg, fl_disc_next;
    logic        cmd_reg, cmd_next;
    logic [31:0] sx_reg, sx_next, sy_reg, sy_next, ex_reg, ex_next, ey_reg, ey_next;
    logic [31:0] nw_reg, nw_next, fw_reg, fw_next, span_reg, span_next;
    logic [7:0]  red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [15:0] hot_reg, hot_next, cold_reg, cold_next;
    logic [31:0] amx_reg, amx_next, amy_reg, amy_next;
    logic        dxneg_reg, dxneg_next, dyneg_reg, dyneg_next, big_reg, big_next;
    logic [63:0] sq_reg, sq_next, rn_reg, rn_next, res_reg, res_next, bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [bwd_pkg::LEN_W-1:0] len_reg, len_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [bwd_pkg::OFF_W-1:0] nox_reg, nox_next, noy_reg, noy_next;
    logic [bwd_pkg::OFF_W-1:0] fox_reg, fox_next, foy_reg, foy_next;

    logic [32:0] dx, dy, ndx, ndy;
    logic [31:0] p_eff, wn, wf, span_eff, hx, hy, mul_a, mul_b;
    logic [63:0] prod, root_try, qr;
    logic [bwd_pkg::DSR_W-1:0] divisor, div_rem;
    logic [63:0] div_quot;
    logic        div_start, div_busy, rnd_up, off_neg;
    logic [bwd_pkg::OFF_W-1:0] off_val;
    logic [16:0] cold_sum;

    bwd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dvd_reg),
        .divisor   (divisor),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb begin
        p_eff = (pix_reg == 32'd0) ? 32'd1 : pix_reg;
        wn = (nw_reg > fl_near_reg) ? nw_reg : fl_near_reg;
        wf = (fw_reg > fl_far_reg) ? fw_reg : fl_far_reg;
        span_eff = (span_reg < bwd_pkg::FADE_SPAN_MIN) ? bwd_pkg::FADE_SPAN_MIN : span_reg;
        hx = big_reg ? {1'b0, amx_reg[31:1]} : amx_reg;
        hy = big_reg ? {1'b0, amy_reg[31:1]} : amy_reg;
        dx = {s_end_x[31], s_end_x} - {s_start_x[31], s_start_x};
        dy = {s_end_y[31], s_end_y} - {s_start_y[31], s_start_y};
        ndx = -dx;
        ndy = -dy;

        mul_a = '0;
        mul_b = '0;
        if (state_reg == bwd_pkg::F_SQX) begin
            mul_a = hx;
            mul_b = hx;
        end else if (state_reg == bwd_pkg::F_SQY) begin
            mul_a = hy;
            mul_b = hy;
        end else begin
            case (op_reg)
                bwd_pkg::OP_NEAR_X: begin mul_a = amy_reg; mul_b = wn; end
                bwd_pkg::OP_NEAR_Y: begin mul_a = amx_reg; mul_b = wn; end
                bwd_pkg::OP_FAR_X:  begin mul_a = amy_reg; mul_b = wf; end
                bwd_pkg::OP_FAR_Y:  begin mul_a = amx_reg; mul_b = wf; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        prod = 64'(mul_a) * 64'(mul_b);

        if (op_reg == bwd_pkg::OP_FLOOR_NEAR || op_reg == bwd_pkg::OP_FLOOR_FAR
            || op_reg == bwd_pkg::OP_FLOOR_DISC) begin
            divisor = {3'b000, p_eff};
        end else if (op_reg == bwd_pkg::OP_FADE) begin
            divisor = {3'b000, span_eff};
        end else begin
            divisor = {len_reg, 1'b0};
        end

        rnd_up = {div_rem, 1'b0} >= {1'b0, divisor};
        qr = div_quot + 64'(rnd_up);
        off_neg = (op_reg == bwd_pkg::OP_NEAR_X || op_reg == bwd_pkg::OP_FAR_X)
                  ? !dyneg_reg : dxneg_reg;
        off_val = off_neg ? -{1'b0, qr[bwd_pkg::OFF_W-2:0]} : {1'b0, qr[bwd_pkg::OFF_W-2:0]};
        cold_sum = {1'b0, hot_reg} + {1'b0, div_quot[15:0]};
        root_try = res_reg + bit_reg;
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        pix_next = pix_reg;
        fl_near_next = fl_near_reg;
        fl_far_next = fl_far_reg;
        fl_disc_next = fl_disc_reg;
        cmd_next = cmd_reg;
        sx_next = sx_reg; sy_next = sy_reg; ex_next = ex_reg; ey_next = ey_reg;
        nw_next = nw_reg; fw_next = fw_reg; span_next = span_reg;
        red_next = red_reg; green_next = green_reg; blue_next = blue_reg;
        hot_next = hot_reg; cold_next = cold_reg;
        amx_next = amx_reg; amy_next = amy_reg;
        dxneg_next = dxneg_reg; dyneg_next = dyneg_reg; big_next = big_reg;
        sq_next = sq_reg; rn_next = rn_reg; res_next = res_reg; bit_next = bit_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        dvd_next = dvd_reg;
        nox_next = nox_reg; noy_next = noy_reg; fox_next = fox_reg; foy_next = foy_reg;
        div_start = 1'b0;
        s_ready = 1'b0;
        job_valid = 1'b0;

        unique case (state_reg)
            bwd_pkg::F_IDLE: begin
                s_ready = !cfg_wr_en;
                if (s_valid && !cfg_wr_en) begin
                    cmd_next = s_command;
                    sx_next = s_start_x; sy_next = s_start_y;
                    ex_next = s_end_x; ey_next = s_end_y;
                    nw_next = s_near_width; fw_next = s_far_width;
                    red_next = s_red; green_next = s_green; blue_next = s_blue;
                    hot_next = s_fade_begin; span_next = s_fade_span;
                    amx_next = dx[32] ? ndx[31:0] : dx[31:0];
                    amy_next = dy[32] ? ndy[31:0] : dy[31:0];
                    dxneg_next = dx[32];
                    dyneg_next = dy[32];
                    big_next = amx_next[31] | amy_next[31];
                    state_next = (s_command == bwd_pkg::CMD_DISC) ? bwd_pkg::F_PUSH
                                                                   : bwd_pkg::F_SQX;
                end
            end
            bwd_pkg::F_SQX: begin
                sq_next = prod;
                state_next = bwd_pkg::F_SQY;
            end
            bwd_pkg::F_SQY: begin
                sq_next = sq_reg + prod;
                state_next = bwd_pkg::F_CHK;
            end
            bwd_pkg::F_CHK: begin
                if (!big_reg && sq_reg < bwd_pkg::BEAM_MIN_SQ) begin
                    state_next = bwd_pkg::F_IDLE;
                end else begin
                    rn_next = sq_reg;
                    res_next = '0;
                    bit_next = 64'd1 << 62;
                    cnt_next = 5'd31;
                    state_next = bwd_pkg::F_ROOT;
                end
            end
            bwd_pkg::F_ROOT: begin
                if (rn_reg >= root_try) begin
                    rn_next = rn_reg - root_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    len_next = big_reg ? {res_next[32:0], 1'b0} : res_next[33:0];
                    op_next = bwd_pkg::OP_NEAR_X;
                    state_next = bwd_pkg::F_MUL;
                end
            end
            bwd_pkg::F_MUL: begin
                case (op_reg)
                    bwd_pkg::OP_FLOOR_NEAR: dvd_next = 64'd1 << 32;
                    bwd_pkg::OP_FLOOR_FAR:  dvd_next = 64'd9 << 31;
                    bwd_pkg::OP_FLOOR_DISC: dvd_next = 64'd1 << 33;
                    bwd_pkg::OP_FADE: dvd_next = {22'd0, len_reg, 8'd0}
                                                 + {33'd0, span_eff[31:1]};
                    default: dvd_next = prod;
                endcase
                state_next = bwd_pkg::F_START;
            end
            bwd_pkg::F_START: begin
                div_start = 1'b1;
                state_next = bwd_pkg::F_WAIT;
            end
            bwd_pkg::F_WAIT: begin
                if (!div_busy) begin
                    state_next = bwd_pkg::F_RND;
                end
            end
            bwd_pkg::F_RND: begin
                case (op_reg)
                    bwd_pkg::OP_FLOOR_NEAR:
                        fl_near_next = (|div_quot[63:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
                    bwd_pkg::OP_FLOOR_FAR:
                        fl_far_next = (|div_quot[63:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
                    bwd_pkg::OP_FLOOR_DISC:
                        fl_disc_next = (|div_quot[63:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
                    bwd_pkg::OP_NEAR_X: nox_next = off_val;
                    bwd_pkg::OP_NEAR_Y: noy_next = off_val;
                    bwd_pkg::OP_FAR_X:  fox_next = off_val;
                    bwd_pkg::OP_FAR_Y:  foy_next = off_val;
                    default: cold_next = ((|div_quot[63:16]) || cold_sum[16])
                                         ? 16'hFFFF : cold_sum[15:0];
                endcase
                op_next = op_reg + 3'd1;
                if (op_reg == bwd_pkg::OP_FLOOR_DISC) begin
                    state_next = bwd_pkg::F_IDLE;
                end else if (op_reg == bwd_pkg::OP_FADE) begin
                    state_next = bwd_pkg::F_PUSH;
                end else begin
                    state_next = bwd_pkg::F_MUL;
                end
            end
            bwd_pkg::F_PUSH: begin
                job_valid = 1'b1;
                if (job_ready) begin
                    state_next = bwd_pkg::F_IDLE;
                end
            end
            default: state_next = bwd_pkg::F_IDLE;
        endcase

        if (cfg_wr_en) begin
            pix_next = cfg_wr_data;
            op_next = bwd_pkg::OP_FLOOR_NEAR;
            state_next = bwd_pkg::F_MUL;
        end
    end

    always_comb begin
        job.is_disc = cmd_reg;
        job.sx = sx_reg;
        job.sy = sy_reg;
        job.ex = ex_reg;
        job.ey = ey_reg;
        job.nox = nox_reg;
        job.noy = noy_reg;
        job.fox = fox_reg;
        job.foy = foy_reg;
        job.radius = (nw_reg > fl_disc_reg) ? nw_reg : fl_disc_reg;
        job.hot = hot_reg;
        job.cold = cold_reg;
        job.red = red_reg;
        job.green = green_reg;
        job.blue = blue_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bwd_pkg::F_MUL;
            op_reg <= bwd_pkg::OP_FLOOR_NEAR;
            pix_reg <= bwd_pkg::PIX_RESET;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            pix_reg <= pix_next;
        end
        fl_near_reg <= fl_near_next;
        fl_far_reg <= fl_far_next;
        fl_disc_reg <= fl_disc_next;
        cmd_reg <= cmd_next;
        sx_reg <= sx_next; sy_reg <= sy_next; ex_reg <= ex_next; ey_reg <= ey_next;
        nw_reg <= nw_next; fw_reg <= fw_next; span_reg <= span_next;
        red_reg <= red_next; green_reg <= green_next; blue_reg <= blue_next;
        hot_reg <= hot_next; cold_reg <= cold_next;
        amx_reg <= amx_next; amy_reg <= amy_next;
        dxneg_reg <= dxneg_next; dyneg_reg <= dyneg_next; big_reg <= big_next;
        sq_reg <= sq_next; rn_reg <= rn_next; res_reg <= res_next; bit_reg <= bit_next;
        cnt_reg <= cnt_next;
        len_reg <= len_next;
        dvd_reg <= dvd_next;
        nox_reg <= nox_next; noy_reg <= noy_next; fox_reg <= fox_next; foy_reg <= foy_next;
    end
endmodule
`default_nettype wire

/* sv/bwd_queue.sv */
// Two-entry job queue between the front end and the vertex emitter.
`timescale 1ns / 1ps
`default_nettype none
module bwd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bwd_pkg::job_t  in_job,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bwd_pkg::job_t       out_job
);
    bwd_pkg::job_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb begin
        in_ready = count_reg != 2'd2;
        out_valid = count_reg != 2'd0;
        push = in_valid && in_ready;
        pop = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
        out_job = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end
endmodule
`default_nettype wire

/* sv/bwd_back.sv */
// Back end: walks one job and emits its vertices through an output register.
`timescale 1ns / 1ps
`default_nettype none
module bwd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire bwd_pkg::job_t  job,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [31:0]         m_vertex_x,
    output logic [31:0]         m_vertex_y,
    output logic [7:0]          m_out_red,
    output logic [7:0]          m_out_green,
    output logic [7:0]          m_out_blue,
    output logic [15:0]         m_fade_distance,
    output logic                m_last_vertex
);
    localparam int SW = bwd_pkg::SEG_W;
    localparam int OW = bwd_pkg::OFF_W;

    logic          active_reg, active_next;
    bwd_pkg::job_t job_reg, job_next;
    logic [2:0]    vcnt_reg, vcnt_next;
    logic [SW-1:0] seg_reg, seg_next;
    logic [1:0]    ph_reg, ph_next;
    logic [OW-1:0] px_reg, px_next, py_reg, py_next;
    logic [62:0]   prodx_reg, prodx_next, prody_reg, prody_next;
    logic          negx_reg, negx_next, negy_reg, negy_next;
    logic          mv_reg, mv_next, last_reg, last_next;
    logic [31:0]   x_reg, x_next, y_reg, y_next;
    logic [7:0]    r_reg, r_next, g_reg, g_next, b_reg, b_next;
    logic [15:0]   fade_reg, fade_next;

    logic          adv, v_last;
    logic [31:0]   bx, by;
    logic [OW-1:0] ox, oy, qx, qy;
    logic [15:0]   v_fade;
    logic [32:0]   qmx, qmy;

    always_comb begin
        adv = active_reg && (!mv_reg || m_ready);
        qmx = {1'b0, prodx_reg[61:30]} + 33'(prodx_reg[29]);
        qmy = {1'b0, prody_reg[61:30]} + 33'(prody_reg[29]);
        qx = negx_reg ? -{2'b00, qmx} : {2'b00, qmx};
        qy = negy_reg ? -{2'b00, qmy} : {2'b00, qmy};
        bx = job_reg.sx;
        by = job_reg.sy;
        ox = '0;
        oy = '0;
        v_fade = 16'd0;
        v_last = 1'b0;
        if (job_reg.is_disc) begin
            case (ph_reg)
                2'd1: begin
                    ox = px_reg; oy = py_reg; v_fade = bwd_pkg::RIM_FADE;
                end
                2'd2: begin
                    ox = qx; oy = qy; v_fade = bwd_pkg::RIM_FADE;
                    v_last = seg_reg == SW'(bwd_pkg::DISC_SEGMENTS);
                end
                default: begin
                    ox = '0; oy = '0;
                end
            endcase
        end else begin
            case (vcnt_reg)
                3'd1: begin
                    bx = job_reg.ex; by = job_reg.ey;
                    ox = job_reg.fox; oy = job_reg.foy; v_fade = job_reg.cold;
                end
                3'd2: begin
                    ox = job_reg.nox; oy = job_reg.noy; v_fade = job_reg.hot;
                end
                3'd4: begin
                    bx = job_reg.ex; by = job_reg.ey;
                    ox = -job_reg.fox; oy = -job_reg.foy; v_fade = job_reg.cold;
                end
                3'd5: begin
                    bx = job_reg.ex; by = job_reg.ey;
                    ox = job_reg.fox; oy = job_reg.foy; v_fade = job_reg.cold;
                    v_last = 1'b1;
                end
                default: begin
                    ox = -job_reg.nox; oy = -job_reg.noy; v_fade = job_reg.hot;
                end
            endcase
        end
    end

    always_comb begin
        active_next = active_reg;
        job_next = job_reg;
        vcnt_next = vcnt_reg;
        seg_next = seg_reg;
        ph_next = ph_reg;
        px_next = px_reg;
        py_next = py_reg;
        prodx_next = prodx_reg;
        prody_next = prody_reg;
        negx_next = negx_reg;
        negy_next = negy_reg;
        mv_next = mv_reg;
        x_next = x_reg; y_next = y_reg;
        r_next = r_reg; g_next = g_reg; b_next = b_reg;
        fade_next = fade_reg;
        last_next = last_reg;
        job_ready = !active_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        if (!active_reg && job_valid) begin
            active_next = 1'b1;
            job_next = job;
            vcnt_next = 3'd0;
            seg_next = SW'(1);
            ph_next = 2'd0;
            px_next = {3'b000, job.radius};
            py_next = '0;
        end

        if (adv) begin
            mv_next = 1'b1;
            x_next = bwd_pkg::sat_add(bx, ox);
            y_next = bwd_pkg::sat_add(by, oy);
            r_next = job_reg.red;
            g_next = job_reg.green;
            b_next = job_reg.blue;
            fade_next = v_fade;
            last_next = v_last;
            if (job_reg.is_disc) begin
                case (ph_reg)
                    2'd0: begin
                        prodx_next = 63'(bwd_pkg::COS_MAG[seg_reg]) * 63'(job_reg.radius);
                        prody_next = 63'(bwd_pkg::SIN_MAG[seg_reg]) * 63'(job_reg.radius);
                        negx_next = bwd_pkg::COS_NEG[seg_reg];
                        negy_next = bwd_pkg::SIN_NEG[seg_reg];
                        ph_next = 2'd1;
                    end
                    2'd1: ph_next = 2'd2;
                    default: begin
                        px_next = qx;
                        py_next = qy;
                        ph_next = 2'd0;
                        seg_next = seg_reg + SW'(1);
                    end
                endcase
            end else begin
                vcnt_next = vcnt_reg + 3'd1;
            end
            if (v_last) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            mv_reg <= mv_next;
        end
        job_reg <= job_next;
        vcnt_reg <= vcnt_next;
        seg_reg <= seg_next;
        ph_reg <= ph_next;
        px_reg <= px_next;
        py_reg <= py_next;
        prodx_reg <= prodx_next;
        prody_reg <= prody_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        x_reg <= x_next; y_reg <= y_next;
        r_reg <= r_next; g_reg <= g_next; b_reg <= b_next;
        fade_reg <= fade_next;
        last_reg <= last_next;
    end

    assign m_valid = mv_reg;
    assign m_vertex_x = x_reg;
    assign m_vertex_y = y_reg;
    assign m_out_red = r_reg;
    assign m_out_green = g_reg;
    assign m_out_blue = b_reg;
    assign m_fade_distance = fade_reg;
    assign m_last_vertex = last_reg;
endmodule
`default_nettype wire

/* sv/beam_wedge_and_disc_vertex_gen_top.sv */
// Top level of the beam wedge and charge disc vertex generator.
// A charge item gives 48 vertices, one per cycle while m_ready is held high.
// A beam item runs a 32-step square root and five 64-step divisions on one shared
// bit-serial divider in the front end; unless too short, it then gives 6 vertices.
// A two-entry job queue lets the front end take new items while vertices drain.
// After reset and after each write of pixels_per_unit, three floor divisions run;
// no item is accepted until they finish.
`timescale 1ns / 1ps
`default_nettype none
module beam_wedge_and_disc_vertex_gen_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [31:0] s_start_x,
    input  wire logic [31:0] s_start_y,
    input  wire logic [31:0] s_end_x,
    input  wire logic [31:0] s_end_y,
    input  wire logic [31:0] s_near_width,
    input  wire logic [31:0] s_far_width,
    input  wire logic [7:0]  s_red,
    input  wire logic [7:0]  s_green,
    input  wire logic [7:0]  s_blue,
    input  wire logic [15:0] s_fade_begin,
    input  wire logic [31:0] s_fade_span,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_vertex_x,
    output logic [31:0]      m_vertex_y,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic [15:0]      m_fade_distance,
    output logic             m_last_vertex
);
    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    bwd_pkg::job_t fq_job, qb_job;

    bwd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_near_width (s_near_width),
        .s_far_width  (s_far_width),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_fade_begin (s_fade_begin),
        .s_fade_span  (s_fade_span),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job)
    );

    bwd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    bwd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (qb_valid),
        .job_ready       (qb_ready),
        .job             (qb_job),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_x      (m_vertex_x),
        .m_vertex_y      (m_vertex_y),
        .m_out_red       (m_out_red),
        .m_out_green     (m_out_green),
        .m_out_blue      (m_out_blue),
        .m_fade_distance (m_fade_distance),
        .m_last_vertex   (m_last_vertex)
    );
endmodule
`default_nettype wire
